[rtl/fdrt_pkg.sv]
package fdrt_pkg;

	// Default framebuffer capacity in pixels.
	localparam int DefMaxWidth = 512;
	localparam int DefMaxHeight = 512;

	// Fixed widths of the register file and the request fields.
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 16;
	localparam int DimW = 10;
	localparam int CoordW = 12;
	localparam int ChanW = 8;
	localparam int ColourW = 16;
	localparam int BoxW = 9;
	localparam int WinW = 16;

	// Depth of the queue between the front and the back end (a power of two).
	localparam int QueueDepth = 4;

	// Reset values.
	localparam logic [DimW-1:0] ResetFrameWidth = 10'd320;
	localparam logic [DimW-1:0] ResetFrameHeight = 10'd480;
	localparam logic [DimW-1:0] EmptyMin = '1;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_FRAME_WIDTH,
		CFG_FRAME_HEIGHT,
		CFG_OFFSET_X,
		CFG_OFFSET_Y
	} cfg_index_t;

	typedef enum logic [1:0] {
		STATUS_CHANGED,
		STATUS_UNCHANGED,
		STATUS_RANGE,
		STATUS_FLUSH
	} status_t;

	// What the back end has to do with a request.
	typedef enum logic [1:0] {
		KIND_DRAW,
		KIND_REJECT,
		KIND_FLUSH
	} kind_t;

	// Classified request as it travels from the front to the back end.
	typedef struct packed {
		kind_t kind;
		logic [DimW-1:0] x;
		logic [DimW-1:0] y;
		logic [ColourW-1:0] colour;
	} op_t;

	// Truncate an 8-bit RGB triple to RGB565.
	function automatic logic [ColourW-1:0] pack565(
		input logic [ChanW-1:0] r,
		input logic [ChanW-1:0] g,
		input logic [ChanW-1:0] b
	);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

[rtl/fdrt_queue.sv]
module fdrt_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [DATA_W-1:0] push_data,
	input logic pop,
	output logic [DATA_W-1:0] head_data,
	output logic empty,
	output logic full
);
	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [PtrW:0] count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == (PtrW+1)'(DEPTH));
	assign head_data = slot_q[rd_ptr_q];

	// Storage slots; written only on a push.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count. DEPTH is a power of two, so pointers wrap naturally.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/fdrt_front.sv]
module fdrt_front #(
	parameter int MAX_WIDTH = fdrt_pkg::DefMaxWidth,
	parameter int MAX_HEIGHT = fdrt_pkg::DefMaxHeight,
	parameter int ADDR_W = 18
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic action,
	input logic [fdrt_pkg::CoordW-1:0] pixel_x,
	input logic [fdrt_pkg::CoordW-1:0] pixel_y,
	input logic [fdrt_pkg::ChanW-1:0] red,
	input logic [fdrt_pkg::ChanW-1:0] green,
	input logic [fdrt_pkg::ChanW-1:0] blue,
	input logic busy,
	input logic [fdrt_pkg::DimW-1:0] frame_width,
	input logic [fdrt_pkg::DimW-1:0] frame_height,
	input logic q_full,
	output logic push,
	output fdrt_pkg::op_t push_op,
	output logic [ADDR_W-1:0] push_addr
);
	import fdrt_pkg::*;

	logic [DimW-1:0] eff_w;
	logic [DimW-1:0] eff_h;
	logic x_ok;
	logic y_ok;
	logic accept;
	op_t op_next;
	logic valid_s1;
	op_t op_s1;
	logic [2*DimW-1:0] row_base;
	logic [2*DimW:0] pos;

	// Frame size clipped to the framebuffer capacity.
	always_comb begin
		if (int'(frame_width) > MAX_WIDTH) begin
			eff_w = DimW'(MAX_WIDTH);
		end else begin
			eff_w = frame_width;
		end
		if (int'(frame_height) > MAX_HEIGHT) begin
			eff_h = DimW'(MAX_HEIGHT);
		end else begin
			eff_h = frame_height;
		end
	end

	// Range check: non-negative and below the active size.
	assign x_ok = !pixel_x[CoordW-1] && (pixel_x[CoordW-2:0] < (CoordW-1)'(eff_w));
	assign y_ok = !pixel_y[CoordW-1] && (pixel_y[CoordW-2:0] < (CoordW-1)'(eff_h));

	// Classify the incoming request.
	always_comb begin
		op_next.x = pixel_x[DimW-1:0];
		op_next.y = pixel_y[DimW-1:0];
		op_next.colour = pack565(red, green, blue);
		if (action) begin
			op_next.kind = KIND_FLUSH;
		end else if (x_ok && y_ok) begin
			op_next.kind = KIND_DRAW;
		end else begin
			op_next.kind = KIND_REJECT;
		end
	end

	assign in_stall = busy || (valid_s1 && q_full);
	assign accept = in_valid && !in_stall;
	assign push = valid_s1 && !q_full;

	// Classification stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_next;
		end
	end

	// Pixel address: row times stride plus column, registered by the queue.
	assign row_base = op_s1.y * eff_w;
	assign pos = {1'b0, row_base} + (2*DimW+1)'(op_s1.x);
	assign push_addr = ADDR_W'(pos);
	assign push_op = op_s1;

endmodule

[rtl/fdrt_back.sv]
module fdrt_back #(
	parameter int MAX_WIDTH = fdrt_pkg::DefMaxWidth,
	parameter int MAX_HEIGHT = fdrt_pkg::DefMaxHeight,
	parameter int ADDR_W = 18
) (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input fdrt_pkg::op_t head_op,
	input logic [ADDR_W-1:0] head_addr,
	output logic pop,
	output logic busy,
	input logic [fdrt_pkg::WinW-1:0] panel_offset_x,
	input logic [fdrt_pkg::WinW-1:0] panel_offset_y,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] draw_status,
	output logic box_valid,
	output logic [fdrt_pkg::BoxW-1:0] box_x_first,
	output logic [fdrt_pkg::BoxW-1:0] box_y_first,
	output logic [fdrt_pkg::BoxW-1:0] box_x_last,
	output logic [fdrt_pkg::BoxW-1:0] box_y_last,
	output logic [fdrt_pkg::WinW-1:0] window_col_start,
	output logic [fdrt_pkg::WinW-1:0] window_col_end,
	output logic [fdrt_pkg::WinW-1:0] window_row_start,
	output logic [fdrt_pkg::WinW-1:0] window_row_end
);
	import fdrt_pkg::*;

	localparam int Depth = MAX_WIDTH * MAX_HEIGHT;

	typedef struct packed {
		status_t status;
		logic box_valid;
		logic [BoxW-1:0] x_first;
		logic [BoxW-1:0] y_first;
		logic [BoxW-1:0] x_last;
		logic [BoxW-1:0] y_last;
		logic [WinW-1:0] col_start;
		logic [WinW-1:0] col_end;
		logic [WinW-1:0] row_start;
		logic [WinW-1:0] row_end;
	} result_t;

	logic [ColourW-1:0] mem [Depth];
	logic [ColourW-1:0] rdata_q;

	logic clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic valid_s2;
	op_t op_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic advance;

	logic last_valid_q;
	logic [ADDR_W-1:0] last_addr_q;
	logic [ColourW-1:0] last_data_q;

	logic [DimW-1:0] x_min_q;
	logic [DimW-1:0] y_min_q;
	logic [DimW-1:0] x_max_q;
	logic [DimW-1:0] y_max_q;

	logic [ColourW-1:0] old_colour;
	logic changed;
	logic commit_write;
	logic box_ok;
	result_t res;
	result_t res_q;
	logic out_valid_q;

	logic mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ColourW-1:0] mem_wdata;

	assign busy = clearing_q;

	// Handshake between the queue, the read stage and the output register.
	assign advance = valid_s2 && (!out_valid_q || !out_stall);
	assign pop = !q_empty && (!valid_s2 || advance);

	// Framebuffer write port: clearing pass first, then committed draws.
	always_comb begin
		if (clearing_q) begin
			mem_we = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we = commit_write;
			mem_waddr = addr_s2;
			mem_wdata = op_s2.colour;
		end
	end

	// Framebuffer storage with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (pop) begin
			rdata_q <= mem[head_addr];
		end
	end

	// Clearing pass after reset, one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(Depth - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Read stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (pop) begin
			valid_s2 <= 1'b1;
		end else if (advance) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s2 <= head_op;
			addr_s2 <= head_addr;
		end
	end

	// The most recent draw write, forwarded when it lands on the same address
	// as the request being compared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_valid_q <= 1'b0;
		end else if (commit_write) begin
			last_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_write) begin
			last_addr_q <= addr_s2;
			last_data_q <= op_s2.colour;
		end
	end

	assign old_colour = (last_valid_q && (last_addr_q == addr_s2)) ? last_data_q : rdata_q;
	assign changed = (old_colour != op_s2.colour);
	assign commit_write = advance && (op_s2.kind == KIND_DRAW) && changed;
	assign box_ok = (x_min_q <= x_max_q) && (y_min_q <= y_max_q);

	// Result of the request in the read stage.
	always_comb begin
		res = '0;
		unique case (op_s2.kind)
			KIND_DRAW: begin
				res.status = changed ? STATUS_CHANGED : STATUS_UNCHANGED;
			end
			KIND_FLUSH: begin
				res.status = STATUS_FLUSH;
				if (box_ok) begin
					res.box_valid = 1'b1;
					res.x_first = x_min_q[BoxW-1:0];
					res.y_first = y_min_q[BoxW-1:0];
					res.x_last = x_max_q[BoxW-1:0];
					res.y_last = y_max_q[BoxW-1:0];
					res.col_start = WinW'(x_min_q) + panel_offset_x;
					res.col_end = WinW'(x_max_q) + panel_offset_x;
					res.row_start = WinW'(y_min_q) + panel_offset_y;
					res.row_end = WinW'(y_max_q) + panel_offset_y;
				end
			end
			default: begin
				res.status = STATUS_RANGE;
			end
		endcase
	end

	// Dirty box: grows on a changed pixel, empties on a flush.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= EmptyMin;
			y_min_q <= EmptyMin;
			x_max_q <= '0;
			y_max_q <= '0;
		end else if (advance && (op_s2.kind == KIND_FLUSH)) begin
			x_min_q <= EmptyMin;
			y_min_q <= EmptyMin;
			x_max_q <= '0;
			y_max_q <= '0;
		end else if (commit_write) begin
			if (op_s2.x < x_min_q) begin
				x_min_q <= op_s2.x;
			end
			if (op_s2.y < y_min_q) begin
				y_min_q <= op_s2.y;
			end
			if (op_s2.x > x_max_q) begin
				x_max_q <= op_s2.x;
			end
			if (op_s2.y > y_max_q) begin
				y_max_q <= op_s2.y;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign draw_status = res_q.status;
	assign box_valid = res_q.box_valid;
	assign box_x_first = res_q.x_first;
	assign box_y_first = res_q.y_first;
	assign box_x_last = res_q.x_last;
	assign box_y_last = res_q.y_last;
	assign window_col_start = res_q.col_start;
	assign window_col_end = res_q.col_end;
	assign window_row_start = res_q.row_start;
	assign window_row_end = res_q.row_end;

endmodule

[rtl/framebuffer_dirty_rect_tracker_core.sv]
// Channel   Direction  Handshake            Payload
// in        request    in_valid / in_stall  action, pixel_x, pixel_y, red, green, blue
// out       result     out_valid / out_stall draw_status, box_*, window_*
// cfg       write      cfg_we               cfg_index, cfg_data
//
// One request is taken per clock while in_stall is low, one result leaves per
// clock while out_stall is low; stages: classify, queue, read, output register.
// The framebuffer has one read and one write port; a draw reads, compares and
// writes back in a single pass, with the previous write forwarded.
// After reset a clearing pass writes zero to all MAX_WIDTH*MAX_HEIGHT entries,
// one per cycle, while in_stall is held high; configuration writes are taken.
// A stalled output fills the queue between front and back before in_stall rises.
module framebuffer_dirty_rect_tracker_core #(
	parameter int MAX_WIDTH = fdrt_pkg::DefMaxWidth,
	parameter int MAX_HEIGHT = fdrt_pkg::DefMaxHeight
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [fdrt_pkg::CfgIdxW-1:0] cfg_index,
	input logic [fdrt_pkg::CfgDataW-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic action,
	input logic [fdrt_pkg::CoordW-1:0] pixel_x,
	input logic [fdrt_pkg::CoordW-1:0] pixel_y,
	input logic [fdrt_pkg::ChanW-1:0] red,
	input logic [fdrt_pkg::ChanW-1:0] green,
	input logic [fdrt_pkg::ChanW-1:0] blue,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] draw_status,
	output logic box_valid,
	output logic [fdrt_pkg::BoxW-1:0] box_x_first,
	output logic [fdrt_pkg::BoxW-1:0] box_y_first,
	output logic [fdrt_pkg::BoxW-1:0] box_x_last,
	output logic [fdrt_pkg::BoxW-1:0] box_y_last,
	output logic [fdrt_pkg::WinW-1:0] window_col_start,
	output logic [fdrt_pkg::WinW-1:0] window_col_end,
	output logic [fdrt_pkg::WinW-1:0] window_row_start,
	output logic [fdrt_pkg::WinW-1:0] window_row_end
);
	import fdrt_pkg::*;

	localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int QDataW = $bits(op_t) + AddrW;

	logic [DimW-1:0] frame_width_q;
	logic [DimW-1:0] frame_height_q;
	logic [WinW-1:0] col_offset_q;
	logic [WinW-1:0] row_offset_q;

	logic busy;
	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	op_t push_op;
	logic [AddrW-1:0] push_addr;
	logic [QDataW-1:0] head_data;
	op_t head_op;
	logic [AddrW-1:0] head_addr;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= ResetFrameWidth;
			frame_height_q <= ResetFrameHeight;
			col_offset_q <= '0;
			row_offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_FRAME_WIDTH: frame_width_q <= cfg_data[DimW-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[DimW-1:0];
				CFG_OFFSET_X: col_offset_q <= cfg_data;
				CFG_OFFSET_Y: row_offset_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	fdrt_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.ADDR_W(AddrW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.red(red),
		.green(green),
		.blue(blue),
		.busy(busy),
		.frame_width(frame_width_q),
		.frame_height(frame_height_q),
		.q_full(q_full),
		.push(push),
		.push_op(push_op),
		.push_addr(push_addr)
	);

	fdrt_queue #(
		.DATA_W(QDataW),
		.DEPTH(QueueDepth)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({push_op, push_addr}),
		.pop(pop),
		.head_data(head_data),
		.empty(q_empty),
		.full(q_full)
	);

	assign head_op = op_t'(head_data[QDataW-1:AddrW]);
	assign head_addr = head_data[AddrW-1:0];

	fdrt_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.ADDR_W(AddrW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.head_op(head_op),
		.head_addr(head_addr),
		.pop(pop),
		.busy(busy),
		.panel_offset_x(col_offset_q),
		.panel_offset_y(row_offset_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.draw_status(draw_status),
		.box_valid(box_valid),
		.box_x_first(box_x_first),
		.box_y_first(box_y_first),
		.box_x_last(box_x_last),
		.box_y_last(box_y_last),
		.window_col_start(window_col_start),
		.window_col_end(window_col_end),
		.window_row_start(window_row_start),
		.window_row_end(window_row_end)
	);

endmodule
